FILE: rtl/drum_map_step_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the drum map step sequencer
// Shared property templates, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DRUM_MAP_STEP_SEQUENCER_MACROS_SVH
`define DRUM_MAP_STEP_SEQUENCER_MACROS_SVH

// same-cycle implication
`define DMSS_ASSERT_NOW(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("dmss assertion failed");

// next-cycle implication
`define DMSS_ASSERT_NEXT(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("dmss assertion failed");

`endif

FILE: rtl/dmss_pkg.sv
// ----------------------------------------------------------------------------
// dmss_pkg
// Sizes, codes and control types shared by the sequencer modules.
// ----------------------------------------------------------------------------
package dmss_pkg;

	localparam int STEP_COUNT   = 32;
	localparam int GRID_SIDE    = 5;
	localparam int INSTR_COUNT  = 3;
	localparam int NODE_COUNT   = GRID_SIDE * GRID_SIDE;
	localparam int PATTERN_LEN  = INSTR_COUNT * STEP_COUNT;
	localparam int STORE_SIZE   = NODE_COUNT * PATTERN_LEN;
	localparam int ADDR_W       = $clog2(STORE_SIZE);
	localparam int STEP_W       = $clog2(STEP_COUNT);
	localparam int INST_W       = (INSTR_COUNT > 1) ? $clog2(INSTR_COUNT) : 1;
	localparam int COORD_W      = $clog2(GRID_SIDE);
	localparam int NODE_W       = $clog2(NODE_COUNT);
	localparam int POS_W        = 11;
	localparam int FRAC_W       = 8;
	localparam int POS_MAX      = (GRID_SIDE - 1) * 256;
	localparam int ACC_W        = 24;
	localparam int CORNER_W     = 2;

	localparam int ACCENT_LEVEL = 200;
	localparam int CHAOS_SCALE  = 2550;
	localparam int CHAOS_KEEP   = 768;
	localparam int CHAOS_SET    = 256;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	localparam logic [2:0] CFG_MAP_X   = 3'd0;
	localparam logic [2:0] CFG_MAP_Y   = 3'd1;
	localparam logic [2:0] CFG_KICK_D  = 3'd2;
	localparam logic [2:0] CFG_SNARE_D = 3'd3;
	localparam logic [2:0] CFG_HAT_D   = 3'd4;
	localparam logic [2:0] CFG_CHAOS   = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_RUN     = 4'b0010,
		ST_DRAIN   = 4'b0100,
		ST_PUBLISH = 4'b1000
	} dmss_state_t;

	typedef struct packed {
		logic                accept;
		logic                rd;
		logic [INST_W-1:0]   inst;
		logic [CORNER_W-1:0] corner;
		logic                publish;
	} dmss_cmd_t;

	typedef struct packed {
		logic out_free;
	} dmss_sts_t;

endpackage

FILE: rtl/drum_map_step_sequencer.sv
// ----------------------------------------------------------------------------
// drum_map_step_sequencer
// Drum step sequencer over a 5x5 map of stored patterns (3 instruments by 32
// steps). A load transaction (operation 1) writes one pattern byte and is
// taken without leaving the idle state; out-of-range loads are dropped. A tick
// transaction (operation 0) bilinearly blends the four map nodes around
// (map_x, map_y), applies density, chaos and accent, returns one result and
// advances the step. The input is stalled from the acceptance of a tick until
// the block is idle again: the pattern store has one read port and the twelve
// corner reads (three instruments, four nodes) are issued one per cycle,
// followed by a pipeline drain and the hand-off into the output register. The
// next transaction is accepted while a result still waits in the output
// register, but a tick then holds at the hand-off, input stalled, until that
// result has been taken. The pattern store has no reset; reading a
// never-written entry gives an arbitrary level. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module drum_map_step_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_addr,
	input  logic [10:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [4:0]  node_index,
	input  logic [6:0]  pattern_offset,
	input  logic [7:0]  pattern_value,
	input  logic [7:0]  rand_kick,
	input  logic [7:0]  rand_snare,
	input  logic [7:0]  rand_hat,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  step_index,
	output logic        kick_trigger,
	output logic        snare_trigger,
	output logic        hat_trigger,
	output logic        kick_accent,
	output logic        snare_accent,
	output logic        hat_accent,
	output logic [7:0]  kick_level,
	output logic [7:0]  snare_level,
	output logic [7:0]  hat_level
);

	dmss_pkg::dmss_cmd_t cmd;
	dmss_pkg::dmss_sts_t sts;

	dmss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (operation),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dmss_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.operation      (operation),
		.node_index     (node_index),
		.pattern_offset (pattern_offset),
		.pattern_value  (pattern_value),
		.rand_kick      (rand_kick),
		.rand_snare     (rand_snare),
		.rand_hat       (rand_hat),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_index     (step_index),
		.kick_trigger   (kick_trigger),
		.snare_trigger  (snare_trigger),
		.hat_trigger    (hat_trigger),
		.kick_accent    (kick_accent),
		.snare_accent   (snare_accent),
		.hat_accent     (hat_accent),
		.kick_level     (kick_level),
		.snare_level    (snare_level),
		.hat_level      (hat_level)
	);

endmodule

FILE: rtl/dmss_ctrl.sv
// ----------------------------------------------------------------------------
// dmss_ctrl
// Tick sequencer: issues the pattern store reads, waits for the datapath
// pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "drum_map_step_sequencer_macros.svh"

module dmss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_op,
	output logic                in_stall,
	input  dmss_pkg::dmss_sts_t sts,
	output dmss_pkg::dmss_cmd_t cmd
);

	dmss_pkg::dmss_state_t                state_q;
	logic [dmss_pkg::INST_W-1:0]          inst_q;
	logic [dmss_pkg::CORNER_W-1:0]        corner_q;
	logic                                 accept;
	logic                                 last_corner;
	logic                                 last_inst;

	assign in_stall    = (state_q != dmss_pkg::ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign last_corner = (corner_q == {dmss_pkg::CORNER_W{1'b1}});
	assign last_inst   = (inst_q == dmss_pkg::INST_W'(dmss_pkg::INSTR_COUNT - 1));

	always_comb begin
		cmd         = '0;
		cmd.accept  = accept;
		cmd.rd      = (state_q == dmss_pkg::ST_RUN);
		cmd.inst    = inst_q;
		cmd.corner  = corner_q;
		cmd.publish = (state_q == dmss_pkg::ST_PUBLISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dmss_pkg::ST_IDLE;
			inst_q   <= '0;
			corner_q <= '0;
		end else begin
			case (state_q)
				dmss_pkg::ST_IDLE: begin
					inst_q   <= '0;
					corner_q <= '0;
					if (accept && (in_op == dmss_pkg::OP_TICK)) begin
						state_q <= dmss_pkg::ST_RUN;
					end
				end
				dmss_pkg::ST_RUN: begin
					corner_q <= corner_q + 1'b1;
					if (last_corner) begin
						if (last_inst) begin
							inst_q  <= '0;
							state_q <= dmss_pkg::ST_DRAIN;
						end else begin
							inst_q <= inst_q + 1'b1;
						end
					end
				end
				dmss_pkg::ST_DRAIN: begin
					// read data, product and accumulate stages
					if (corner_q[0]) begin
						corner_q <= '0;
						state_q  <= dmss_pkg::ST_PUBLISH;
					end else begin
						corner_q <= corner_q + 1'b1;
					end
				end
				dmss_pkg::ST_PUBLISH: begin
					if (sts.out_free) begin
						state_q <= dmss_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dmss_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`DMSS_ASSERT_NEXT(a_tick_starts_run, accept && (in_op == dmss_pkg::OP_TICK), (state_q == dmss_pkg::ST_RUN) && (inst_q == '0) && (corner_q == '0))
	`DMSS_ASSERT_NOW(a_publish_needs_room, cmd.publish, sts.out_free)

endmodule

FILE: rtl/dmss_datapath.sv
// ----------------------------------------------------------------------------
// dmss_datapath
// Configuration registers, pattern store, bilinear weight and accumulate
// pipeline, density/chaos evaluation and the output register.
// ----------------------------------------------------------------------------
`include "drum_map_step_sequencer_macros.svh"

module dmss_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_addr,
	input  logic [10:0]         cfg_wdata,
	input  logic                operation,
	input  logic [4:0]          node_index,
	input  logic [6:0]          pattern_offset,
	input  logic [7:0]          pattern_value,
	input  logic [7:0]          rand_kick,
	input  logic [7:0]          rand_snare,
	input  logic [7:0]          rand_hat,
	input  dmss_pkg::dmss_cmd_t cmd,
	output dmss_pkg::dmss_sts_t sts,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          step_index,
	output logic                kick_trigger,
	output logic                snare_trigger,
	output logic                hat_trigger,
	output logic                kick_accent,
	output logic                snare_accent,
	output logic                hat_accent,
	output logic [7:0]          kick_level,
	output logic [7:0]          snare_level,
	output logic [7:0]          hat_level
);

	localparam int N = dmss_pkg::INSTR_COUNT;

	// configuration
	logic [dmss_pkg::POS_W-1:0] map_x_q, map_y_q;
	logic [7:0]                 dens_q [N];
	logic [7:0]                 chaos_q;

	logic [7:0] rand_q [N];
	logic [dmss_pkg::STEP_W-1:0] step_q;

	// pattern store
	logic [7:0] mem [dmss_pkg::STORE_SIZE];
	logic       mem_we;
	logic [dmss_pkg::ADDR_W-1:0] waddr, raddr;
	logic [7:0] rdata_q;

	// geometry
	logic [dmss_pkg::POS_W-1:0]   px, py;
	logic [dmss_pkg::FRAC_W-1:0]  fx, fy;
	logic [dmss_pkg::COORD_W-1:0] x0, y0, x1, y1, xs, ys;
	logic [dmss_pkg::NODE_W-1:0]  node;
	logic [8:0]                   wx, wy;
	logic [17:0]                  wgt;

	// pipeline
	logic                          v_s1, v_s2;
	logic [dmss_pkg::INST_W-1:0]   inst_s1, inst_s2;
	logic [dmss_pkg::CORNER_W-1:0] corner_s1, corner_s2;
	logic [16:0]                   w_s1;
	logic [24:0]                   prod_s2;
	logic [dmss_pkg::ACC_W-1:0]    acc_q, sum;
	logic [7:0]                    level;
	logic [7:0]                    dsel, rsel;
	logic                          trig_base, trig, chaos_on;
	logic [19:0]                   r_scaled, c_keep, c_set;

	logic [7:0] lvl_q  [N];
	logic       trig_q [N];
	logic       acc_flag_q [N];

	logic       out_valid_q;
	logic [4:0] out_step_q;
	logic [7:0] out_lvl_q [N];
	logic       out_trig_q [N];
	logic       out_acc_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_x_q <= '0;
			map_y_q <= '0;
			chaos_q <= '0;
			for (int i = 0; i < N; i++) begin
				dens_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			case (cfg_addr)
				dmss_pkg::CFG_MAP_X:   map_x_q   <= cfg_wdata;
				dmss_pkg::CFG_MAP_Y:   map_y_q   <= cfg_wdata;
				dmss_pkg::CFG_KICK_D:  dens_q[0] <= cfg_wdata[7:0];
				dmss_pkg::CFG_SNARE_D: dens_q[1] <= cfg_wdata[7:0];
				dmss_pkg::CFG_HAT_D:   dens_q[2] <= cfg_wdata[7:0];
				dmss_pkg::CFG_CHAOS:   chaos_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// load path
	assign mem_we = cmd.accept && (operation == dmss_pkg::OP_LOAD)
		&& (32'(node_index) < dmss_pkg::NODE_COUNT)
		&& (32'(pattern_offset) < dmss_pkg::PATTERN_LEN);
	assign waddr = dmss_pkg::ADDR_W'(32'(node_index) * dmss_pkg::PATTERN_LEN
		+ 32'(pattern_offset));

	// position and corner weights
	assign px = (32'(map_x_q) > dmss_pkg::POS_MAX) ? dmss_pkg::POS_W'(dmss_pkg::POS_MAX)
		: map_x_q;
	assign py = (32'(map_y_q) > dmss_pkg::POS_MAX) ? dmss_pkg::POS_W'(dmss_pkg::POS_MAX)
		: map_y_q;
	assign fx = px[dmss_pkg::FRAC_W-1:0];
	assign fy = py[dmss_pkg::FRAC_W-1:0];
	assign x0 = px[dmss_pkg::FRAC_W +: dmss_pkg::COORD_W];
	assign y0 = py[dmss_pkg::FRAC_W +: dmss_pkg::COORD_W];
	assign x1 = (32'(x0) >= dmss_pkg::GRID_SIDE - 1) ? x0 : x0 + 1'b1;
	assign y1 = (32'(y0) >= dmss_pkg::GRID_SIDE - 1) ? y0 : y0 + 1'b1;
	assign xs = cmd.corner[0] ? x1 : x0;
	assign ys = cmd.corner[1] ? y1 : y0;
	assign node = dmss_pkg::NODE_W'(32'(ys) * dmss_pkg::GRID_SIDE + 32'(xs));
	assign raddr = dmss_pkg::ADDR_W'(32'(node) * dmss_pkg::PATTERN_LEN
		+ 32'(cmd.inst) * dmss_pkg::STEP_COUNT + 32'(step_q));
	assign wx = cmd.corner[0] ? {1'b0, fx} : 9'd256 - {1'b0, fx};
	assign wy = cmd.corner[1] ? {1'b0, fy} : 9'd256 - {1'b0, fy};
	assign wgt = wx * wy;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= pattern_value;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rand_q[0] <= rand_kick;
			rand_q[1] <= rand_snare;
			rand_q[2] <= rand_hat;
		end
		inst_s1   <= cmd.inst;
		corner_s1 <= cmd.corner;
		w_s1      <= wgt[16:0];
		inst_s2   <= inst_s1;
		corner_s2 <= corner_s1;
		prod_s2   <= rdata_q * w_s1;
	end

	// evaluation of one instrument as its last corner lands
	assign sum       = acc_q + prod_s2[dmss_pkg::ACC_W-1:0];
	assign level     = sum[dmss_pkg::ACC_W-1 -: 8];
	assign dsel      = dens_q[inst_s2];
	assign rsel      = rand_q[inst_s2];
	// ((255-d)*254)/255 reduces to 254-d, and to 0 at full density
	assign trig_base = (dsel == 8'd255) ? (level != 8'd0) : (level > 8'd254 - dsel);
	assign chaos_on  = (chaos_q != 8'd0);
	assign r_scaled  = 20'(rsel) * 20'(dmss_pkg::CHAOS_SCALE);
	assign c_keep    = 20'(chaos_q) * 20'(dmss_pkg::CHAOS_KEEP);
	assign c_set     = 20'(chaos_q) * 20'(dmss_pkg::CHAOS_SET);

	always_comb begin
		trig = trig_base;
		if (chaos_on) begin
			trig = trig_base ? (r_scaled > c_keep) : (r_scaled < c_set);
		end
		if (dsel == 8'd0) begin
			trig = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= (corner_s2 == {dmss_pkg::CORNER_W{1'b1}}) ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && (corner_s2 == {dmss_pkg::CORNER_W{1'b1}})) begin
			lvl_q[inst_s2]      <= level;
			trig_q[inst_s2]     <= trig;
			acc_flag_q[inst_s2] <= trig && (32'(level) > dmss_pkg::ACCENT_LEVEL);
		end
	end

	// output register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
				step_q <= (32'(step_q) == dmss_pkg::STEP_COUNT - 1) ? '0 : step_q + 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_step_q <= 5'(step_q);
			for (int i = 0; i < N; i++) begin
				out_lvl_q[i]  <= lvl_q[i];
				out_trig_q[i] <= trig_q[i];
				out_acc_q[i]  <= acc_flag_q[i];
			end
		end
	end

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign step_index    = out_step_q;
	assign kick_trigger  = out_trig_q[0];
	assign snare_trigger = out_trig_q[1];
	assign hat_trigger   = out_trig_q[2];
	assign kick_accent   = out_acc_q[0];
	assign snare_accent  = out_acc_q[1];
	assign hat_accent    = out_acc_q[2];
	assign kick_level    = out_lvl_q[0];
	assign snare_level   = out_lvl_q[1];
	assign hat_level     = out_lvl_q[2];

	`DMSS_ASSERT_NOW(a_acc_clear_on_first_corner, v_s2 && (corner_s2 == '0), acc_q == '0)
	`DMSS_ASSERT_NOW(a_no_write_during_read, mem_we, !cmd.rd && !v_s1 && !v_s2)

endmodule
